// ----- hw/rtl/gap_pkg.sv -----
// Shared types and fixed constants of the global average pooling unit.
package gap_pkg;

    // Configuration port widths and register indexes
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int SPATIAL_CFG_W = 13;
    localparam int CHANNEL_CFG_W = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_SPATIAL_SIZE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 8'd1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ABS,
        ST_DIVIDE,
        ST_RESULT
    } t_state;

endpackage

// ----- hw/rtl/global_average_pool_unit.sv -----
// Global average pooling: per-channel accumulation and shared iterative divider.
//
//   channel  | direction | signals
//   ---------+-----------+------------------------------------------------
//   input    | in        | i_valid, o_ready, i_sample
//   output   | out       | o_valid, i_ready, o_average, o_channel_index,
//            |           | o_last_channel
//   config   | in        | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
// A sample that does not close a channel is only added to the sum. A sample that
// closes a channel is accepted, then the magnitude of the sum is taken, then the
// one-bit-per-cycle restoring divider works through ACC_W quotient bits (ACC_W =
// SAMPLE_BITS + clog2(MAX_SPATIAL), 28 by default), and last the quotient is
// signed, saturated and loaded.
// A finished average sits in the output register while the next channel streams
// in; the sequencer stalls in its final state only if the previous one is still
// untaken. Reset is synchronous; it clears the sequencer, the counters and the
// sum, and sets both configuration registers to 1. Configuration is always ready.
module global_average_pool_unit #(
    parameter int MAX_SPATIAL  = 4096,
    parameter int MAX_CHANNELS = 1024,
    parameter int SAMPLE_BITS  = 16,
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input samples
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    // averages
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_average,
    output logic [IDX_W-1:0]                   o_channel_index,
    output logic                               o_last_channel,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gap_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [gap_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int ACC_W = SAMPLE_BITS + $clog2(MAX_SPATIAL);
    localparam int SP_W  = $clog2(MAX_SPATIAL + 1);
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int CNT_W = $clog2(ACC_W + 1);

    localparam logic signed [ACC_W:0] SAT_HI =
        {{(ACC_W + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W:0] SAT_LO =
        {{(ACC_W + 2 - SAMPLE_BITS){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    gap_pkg::t_state r_state, n_state;

    logic [gap_pkg::SPATIAL_CFG_W-1:0] r_spatial;
    logic [gap_pkg::CHANNEL_CFG_W-1:0] r_channels;

    logic signed [ACC_W-1:0] r_sum;
    logic [SP_W-1:0]         r_pos;
    logic [IDX_W-1:0]        r_chan;
    logic [IDX_W-1:0]        r_res_chan;
    logic                    r_res_last;
    logic                    r_neg;
    logic [ACC_W-1:0]        r_quo;
    logic [SP_W-1:0]         r_rem;
    logic [CNT_W-1:0]        r_cnt;

    logic [SP_W-1:0] eff_n;
    logic [CH_W-1:0] eff_nc;
    logic            cfg_write;
    logic            in_accept;
    logic            chan_end;
    logic            chan_last;
    logic            out_free;
    logic            load_out;
    logic signed [ACC_W-1:0] sum_next;
    logic [SP_W:0]           rem_shift;
    logic                    rem_ge;
    logic [SP_W:0]           rem_diff;
    logic signed [ACC_W:0]   quo_signed;
    logic signed [SAMPLE_BITS-1:0] avg_sat;

    // Clamp configured sizes to their usable range
    always_comb begin
        if (r_spatial == '0) begin
            eff_n = SP_W'(1);
        end else if (32'(r_spatial) > MAX_SPATIAL) begin
            eff_n = SP_W'(MAX_SPATIAL);
        end else begin
            eff_n = SP_W'(r_spatial);
        end
        if (r_channels == '0) begin
            eff_nc = CH_W'(1);
        end else if (32'(r_channels) > MAX_CHANNELS) begin
            eff_nc = CH_W'(MAX_CHANNELS);
        end else begin
            eff_nc = CH_W'(r_channels);
        end
    end

    // Accumulate and detect the end of a channel
    assign cfg_write = i_cfg_valid && o_cfg_ready;
    assign in_accept = i_valid && o_ready;
    assign sum_next  = r_sum + ACC_W'(i_sample);
    assign chan_end  = (32'(r_pos) + 1 >= 32'(eff_n));
    assign chan_last = (32'(r_chan) + 1 >= 32'(eff_nc));

    // One restoring division step
    assign rem_shift = {r_rem, r_quo[ACC_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, eff_n});
    assign rem_diff  = rem_shift - {1'b0, eff_n};

    // Sign and saturate the quotient
    always_comb begin
        quo_signed = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        if (quo_signed > SAT_HI) begin
            avg_sat = SAMPLE_BITS'(SAT_HI);
        end else if (quo_signed < SAT_LO) begin
            avg_sat = SAMPLE_BITS'(SAT_LO);
        end else begin
            avg_sat = SAMPLE_BITS'(quo_signed);
        end
    end

    assign out_free = !o_valid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gap_pkg::ST_IDLE: begin
                if (in_accept && chan_end) begin
                    n_state = gap_pkg::ST_ABS;
                end
            end
            gap_pkg::ST_ABS: begin
                n_state = gap_pkg::ST_DIVIDE;
            end
            gap_pkg::ST_DIVIDE: begin
                if (r_cnt == CNT_W'(ACC_W - 1)) begin
                    n_state = gap_pkg::ST_RESULT;
                end
            end
            gap_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = gap_pkg::ST_IDLE;
                end
            end
            default: n_state = gap_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_ready     = 1'b0;
        load_out    = 1'b0;
        o_cfg_ready = 1'b1;
        case (r_state)
            gap_pkg::ST_IDLE:   o_ready  = 1'b1;
            gap_pkg::ST_RESULT: load_out = out_free;
            default: begin
                o_ready  = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // Sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gap_pkg::ST_IDLE;
            r_spatial  <= gap_pkg::SPATIAL_CFG_W'(1);
            r_channels <= gap_pkg::CHANNEL_CFG_W'(1);
            r_sum      <= '0;
            r_pos      <= '0;
            r_chan     <= '0;
            r_cnt      <= '0;
            o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            // drop the request once taken, raise it when a result is loaded
            if (load_out) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            if (r_state == gap_pkg::ST_DIVIDE) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (cfg_write) begin
                // any known register write restarts the map
                if (i_cfg_index == gap_pkg::REG_SPATIAL_SIZE) begin
                    r_spatial <= i_cfg_data[gap_pkg::SPATIAL_CFG_W-1:0];
                    r_sum     <= '0;
                    r_pos     <= '0;
                    r_chan    <= '0;
                end else if (i_cfg_index == gap_pkg::REG_CHANNEL_COUNT) begin
                    r_channels <= i_cfg_data[gap_pkg::CHANNEL_CFG_W-1:0];
                    r_sum      <= '0;
                    r_pos      <= '0;
                    r_chan     <= '0;
                end
            end else if (in_accept) begin
                r_sum <= sum_next;
                if (chan_end) begin
                    r_pos  <= '0;
                    r_chan <= chan_last ? '0 : r_chan + IDX_W'(1);
                end else begin
                    r_pos <= r_pos + SP_W'(1);
                end
            end else if (r_state == gap_pkg::ST_ABS) begin
                r_sum <= '0;
            end
        end
    end

    // Divider datapath and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept && chan_end) begin
            r_res_chan <= r_chan;
            r_res_last <= chan_last;
        end
        case (r_state)
            gap_pkg::ST_ABS: begin
                r_neg <= r_sum[ACC_W-1];
                r_quo <= r_sum[ACC_W-1] ? ACC_W'(-r_sum) : ACC_W'(r_sum);
                r_rem <= '0;
            end
            gap_pkg::ST_DIVIDE: begin
                r_quo <= {r_quo[ACC_W-2:0], rem_ge};
                r_rem <= rem_ge ? rem_diff[SP_W-1:0] : rem_shift[SP_W-1:0];
            end
            default: begin
                r_quo <= r_quo;
            end
        endcase
        if (load_out) begin
            o_average       <= avg_sat;
            o_channel_index <= r_res_chan;
            o_last_channel  <= r_res_last;
        end
    end

endmodule

// ----- bench/tb_global_average_pool_unit.sv -----
// Self-checking bench for the global average pooling unit: directed table, then random maps.
module tb_global_average_pool_unit;

    localparam int  RESET_CYCLES   = 12;
    localparam int  SETTLE_CYCLES  = 40;
    localparam int  TAIL_CYCLES    = 64;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  RANDOM_ITEMS   = 960;
    localparam int  SPATIAL_CAP    = 4096;
    localparam int  CHANNEL_CAP    = 1024;
    localparam int  AVG_HI         = 32767;
    localparam int  AVG_LO         = -32768;
    localparam int  SHORT_RUN      = 12;
    localparam int  WRAP_RUN       = 24;

    // Index that no register answers to
    localparam logic [gap_pkg::CFG_INDEX_W-1:0] REG_UNUSED =
        gap_pkg::REG_CHANNEL_COUNT + 8'd1;

    typedef struct packed {
        logic [15:0] average;
        logic [9:0]  channel_index;
        logic        last_channel;
    } t_pool_result;

    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        logic [gap_pkg::CFG_INDEX_W-1:0] index;
        logic [15:0]                     value;
        logic                            pinned;
        t_pool_result                    want;
    } t_row;

    // Directed table: sample rows carry a typed-in average only where it is obvious
    localparam t_row DIRECTED [0:29] = '{
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, '{16'h7FFF, 10'd0, 1'b1}},
        '{ROW_SAMPLE, '0, 16'h8000, 1'b1, '{16'h8000, 10'd0, 1'b1}},
        '{ROW_SAMPLE, '0, 16'h0000, 1'b1, '{16'h0000, 10'd0, 1'b1}},
        '{ROW_CFG, gap_pkg::REG_SPATIAL_SIZE, 16'd2, 1'b0, '0},
        '{ROW_CFG, gap_pkg::REG_CHANNEL_COUNT, 16'd3, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, '{16'h7FFF, 10'd0, 1'b0}},
        '{ROW_SAMPLE, '0, 16'h8000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h8000, 1'b1, '{16'h8000, 10'd1, 1'b0}},
        // minus one over two truncates to zero
        '{ROW_SAMPLE, '0, 16'hFFFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h0000, 1'b1, '{16'h0000, 10'd2, 1'b1}},
        '{ROW_SAMPLE, '0, 16'h0003, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h0000, 1'b0, '0},
        // zero spatial size and zero channel count both act as one
        '{ROW_CFG, gap_pkg::REG_SPATIAL_SIZE, 16'd0, 1'b0, '0},
        '{ROW_CFG, gap_pkg::REG_CHANNEL_COUNT, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'hFFFB, 1'b1, '{16'hFFFB, 10'd0, 1'b1}},
        '{ROW_CFG, gap_pkg::REG_SPATIAL_SIZE, 16'd3, 1'b0, '0},
        '{ROW_CFG, gap_pkg::REG_CHANNEL_COUNT, 16'd2, 1'b0, '0},
        // unknown index mid-channel keeps the partial sum
        '{ROW_SAMPLE, '0, 16'h0064, 1'b0, '0},
        '{ROW_CFG, REG_UNUSED, 16'hFFFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h0064, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h0065, 1'b0, '0},
        // register write mid-channel drops the partial sum
        '{ROW_SAMPLE, '0, 16'h0007, 1'b0, '0},
        '{ROW_CFG, gap_pkg::REG_CHANNEL_COUNT, 16'd2, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'hFFF9, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'hFFF9, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'hFFF8, 1'b1, '{16'hFFF9, 10'd0, 1'b0}},
        // bits above the register width are dropped
        '{ROW_CFG, gap_pkg::REG_SPATIAL_SIZE, 16'hE001, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h0009, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h000A, 1'b0, '0}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [15:0]                     i_sample = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [15:0]                     o_average;
    logic [9:0]                      o_channel_index;
    logic                            o_last_channel;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [gap_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [gap_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Predictor state and its copy of the registers
    logic [12:0]  spatial_reg = 13'd1;
    logic [10:0]  channel_reg = 11'd1;
    longint       sum_acc = 0;
    longint       pos_seen = 0;
    longint       chan_now = 0;

    t_pool_result pending_averages [$];
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           stall_left = 0;
    bit           tx_burst = 1'b0;
    bit           rx_burst = 1'b0;

    global_average_pool_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_average       (o_average),
        .o_channel_index (o_channel_index),
        .o_last_channel  (o_last_channel),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // Add one sample to the channel sum; emit the truncated average on the channel's last position
    function automatic void accumulate_sample(input logic [15:0] s, output bit got,
                                              output t_pool_result r);
        longint n;
        longint nc;
        longint q;
        bit     last;
        n  = (spatial_reg == 0) ? 1 : (spatial_reg > SPATIAL_CAP) ? SPATIAL_CAP : spatial_reg;
        nc = (channel_reg == 0) ? 1 : (channel_reg > CHANNEL_CAP) ? CHANNEL_CAP : channel_reg;
        got = 1'b0;
        r = '0;
        sum_acc += longint'($signed(s));
        pos_seen++;
        if (pos_seen < n) begin
            return;
        end
        q = sum_acc / n;
        if (q > AVG_HI) q = AVG_HI;
        if (q < AVG_LO) q = AVG_LO;
        last = (chan_now + 1 >= nc);
        r.average       = q[15:0];
        r.channel_index = chan_now[9:0];
        r.last_channel  = last;
        got = 1'b1;
        sum_acc  = 0;
        pos_seen = 0;
        chan_now = last ? 0 : chan_now + 1;
    endfunction

    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 9))
            0: begin
                return 16'h7FFF;
            end
            1: begin
                return 16'h8000;
            end
            2: begin
                return 16'($urandom_range(0, 20) - 10);
            end
            default: begin
                return 16'($urandom());
            end
        endcase
    endfunction

    // Hold off until every average is back and the divider has gone quiet
    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [gap_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [gap_pkg::CFG_DATA_W-1:0] d);
        drain_and_settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == gap_pkg::REG_SPATIAL_SIZE) begin
            spatial_reg = d[12:0];
        end else if (idx == gap_pkg::REG_CHANNEL_COUNT) begin
            channel_reg = d[10:0];
        end
        // a known register restarts the map
        if (idx == gap_pkg::REG_SPATIAL_SIZE || idx == gap_pkg::REG_CHANNEL_COUNT) begin
            sum_acc  = 0;
            pos_seen = 0;
            chan_now = 0;
        end
    endtask

    // Present one sample request and predict on acceptance
    task automatic send_sample(input logic [15:0] s, input bit pinned,
                               input t_pool_result want);
        int           gap;
        bit           got;
        t_pool_result r;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        accumulate_sample(s, got, r);
        if (got) begin
            pending_averages.push_back(pinned ? want : r);
        end
    endtask

    // Take averages with random stalls and compare against the oldest expectation
    always @(posedge i_clk) begin
        t_pool_result exp_r;
        int           stall;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && i_ready) begin
            if (pending_averages.size() == 0) begin
                flag_error($sformatf("unexpected average %0d ch %0d last %0b",
                                     $signed(o_average), o_channel_index, o_last_channel));
            end else begin
                exp_r = pending_averages.pop_front();
                if (o_average !== exp_r.average || o_channel_index !== exp_r.channel_index ||
                    o_last_channel !== exp_r.last_channel) begin
                    flag_error($sformatf(
                        "average mismatch: exp %0d ch %0d last %0b, got %0d ch %0d last %0b",
                        $signed(exp_r.average), exp_r.channel_index, exp_r.last_channel,
                        $signed(o_average), o_channel_index, o_last_channel));
                end
            end
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            i_ready    <= (stall == 0);
            stall_left <= stall;
        end else if (!i_ready) begin
            if (stall_left <= 1) begin
                i_ready <= 1'b1;
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
            end
        end
    end

    // Abort when no channel has moved a request for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          n_rand;
        int          len;
        int          pause_at;
        int          unused_at;
        logic [15:0] d;

        n_rand = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int i = 0; i < $size(DIRECTED); i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                write_reg(DIRECTED[i].index, DIRECTED[i].value);
            end else begin
                send_sample(DIRECTED[i].value, DIRECTED[i].pinned, DIRECTED[i].want);
            end
        end

        // Random maps: mostly small sizes, some zero or oversized, phases cut mid-channel
        while (n_rand < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: d = 16'd0;
                1: d = 16'($urandom());
                2: d = 16'($urandom_range(17, 64));
                default: d = 16'($urandom_range(1, 16));
            endcase
            write_reg(gap_pkg::REG_SPATIAL_SIZE, d);
            case ($urandom_range(0, 9))
                0: d = 16'd0;
                1: d = 16'($urandom());
                2: d = 16'($urandom_range(9, 40));
                default: d = 16'($urandom_range(1, 8));
            endcase
            write_reg(gap_pkg::REG_CHANNEL_COUNT, d);
            tx_burst  = ($urandom_range(0, 3) == 0);
            rx_burst  = ($urandom_range(0, 3) == 0);
            len       = $urandom_range(10, 120);
            pause_at  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len - 1) : -1;
            unused_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len - 1) : -1;
            for (int k = 0; k < len; k++) begin
                if (k == pause_at) begin
                    drain_and_settle();
                end
                if (k == unused_at) begin
                    write_reg(8'($urandom_range(REG_UNUSED, 255)), 16'($urandom()));
                end
                send_sample(draw_sample(), 1'b0, '0);
                n_rand++;
            end
        end

        // Oversized spatial size: a short run at the extremes never closes a channel
        write_reg(gap_pkg::REG_SPATIAL_SIZE, 16'h1FFF);
        write_reg(gap_pkg::REG_CHANNEL_COUNT, 16'd2);
        tx_burst = 1'b1;
        rx_burst = 1'b0;
        for (int k = 0; k < SHORT_RUN; k++) begin
            send_sample((k < SHORT_RUN / 2) ? 16'h7FFF : 16'h8000, 1'b0, '0);
        end

        // Oversized channel count: channel indexes climb with no early wrap
        write_reg(gap_pkg::REG_SPATIAL_SIZE, 16'd0);
        write_reg(gap_pkg::REG_CHANNEL_COUNT, 16'hFFFF);
        tx_burst = 1'b0;
        for (int k = 0; k < WRAP_RUN; k++) begin
            if (k == WRAP_RUN / 2) begin
                rx_burst = 1'b1;
            end
            send_sample(draw_sample(), 1'b0, '0);
        end

        // Drain and let the divider run out
        i_valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
